>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the speed loop RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> hw/rtl/dmpsl_pkg.sv
// Shared types, constants and helper functions of the dual motor speed loop.
`timescale 1ns / 1ps

package dmpsl_pkg;

    // Field and register widths
    localparam int CMD_W      = 10;
    localparam int MAG_W      = 9;
    localparam int TGT_W      = 6;
    localparam int POS_IN_W   = 32;
    localparam int PERIOD_W   = 16;
    localparam int WINDOW_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int DUTY_OUT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd2;

    // Register reset values
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD   = 16'd2000;
    localparam logic [WINDOW_W-1:0] RST_WINDOW_TICKS = 24'd200000;
    localparam logic [GAIN_W-1:0]   RST_GAIN         = 16'd10;

    // Command full scale (+/-1.0 in Q8) and target scaling
    localparam logic signed [CMD_W-1:0] CMD_FULL     = 10'sd256;
    localparam logic [8:0]              TGT_MUL      = 9'd316;
    localparam logic [7:0]              DIV5_RECIP   = 8'd205;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture a request and run the window bookkeeping
        logic err_step;  // form the clamped speed error of the selected motor
        logic mul_step;  // register gain * error
        logic sat_step;  // write back the saturated duty
        logic sel_b;     // motor B selected (else motor A)
        logic emit;      // load the result register
    } dmpsl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic win_close; // the request being accepted closes a window
    } dmpsl_status_t;

    // Saturate a Q8 command to +/-1.0
    function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [CMD_W-1:0] raw);
        logic signed [CMD_W-1:0] v;
        v = raw;
        if (raw > CMD_FULL)
        begin
            v = CMD_FULL;
        end
        else if (raw < -CMD_FULL)
        begin
            v = -CMD_FULL;
        end
        return v;
    endfunction

    // floor(mag*316/1280): scale by 316/256, then divide by 5 via 205/1024
    function automatic logic [TGT_W-1:0] target_of(input logic [MAG_W-1:0] mag);
        logic [16:0] scaled;
        logic [8:0]  coarse;
        logic [16:0] recip;
        scaled = 17'(mag) * 17'(TGT_MUL);
        coarse = scaled[16:8];
        recip  = 17'(coarse) * 17'(DIV5_RECIP);
        return recip[15:10];
    endfunction

endpackage

>>> hw/rtl/dual_motor_pwm_speed_loop.sv
// Top level of the dual motor PWM generator with integral speed loop.
//
// Usage:
//   One request per PWM tick on in_valid/in_ready carries two Q8 speed
//   commands and two encoder positions; one result per request leaves on
//   out_valid/out_ready with both PWM levels, bridge direction bits, the
//   current duties and a window_end flag.
//   A request that does not close a sample window goes from acceptance
//   straight to the emit step, which loads the result register; one that
//   closes a window first runs the shared error / multiply / saturate unit
//   once per motor, A then B. The sequencer handles one request at a time
//   and takes no new one until the last result is in the output register.
//   A finished result sits in the output register while the next request is
//   taken; if out_ready stays low the block holds that result and waits with
//   the following one, so nothing is lost or repeated.
//   Reset: registers return to period 2000, window 200000, gain 10; both
//   duties are zero and the first request only captures encoder positions.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at
//   once and belong to idle periods.
`timescale 1ns / 1ps

module dual_motor_pwm_speed_loop #(
    parameter int POS_WIDTH  = 32,
    parameter int DUTY_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [dmpsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmpsl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [dmpsl_pkg::CMD_W-1:0]    speed_cmd_a,
    input  logic signed [dmpsl_pkg::CMD_W-1:0]    speed_cmd_b,
    input  logic signed [dmpsl_pkg::POS_IN_W-1:0] enc_pos_a,
    input  logic signed [dmpsl_pkg::POS_IN_W-1:0] enc_pos_b,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  pwm_a,
    output logic                                  pwm_b,
    output logic                                  dir_a_in1,
    output logic                                  dir_a_in2,
    output logic                                  dir_b_in1,
    output logic                                  dir_b_in2,
    output logic [dmpsl_pkg::DUTY_OUT_W-1:0]      duty_a,
    output logic [dmpsl_pkg::DUTY_OUT_W-1:0]      duty_b,
    output logic                                  window_end
);
    import dmpsl_pkg::*;

    dmpsl_cmd_t    cmd;
    dmpsl_status_t st;

    // Sequencer
    dmpsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd_o     (cmd)
    );

    // Datapath
    dmpsl_dp #(
        .POS_WIDTH  (POS_WIDTH),
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .speed_cmd_a (speed_cmd_a),
        .speed_cmd_b (speed_cmd_b),
        .enc_pos_a   (enc_pos_a),
        .enc_pos_b   (enc_pos_b),
        .cmd         (cmd),
        .st          (st),
        .pwm_a       (pwm_a),
        .pwm_b       (pwm_b),
        .dir_a_in1   (dir_a_in1),
        .dir_a_in2   (dir_a_in2),
        .dir_b_in1   (dir_b_in1),
        .dir_b_in2   (dir_b_in2),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .window_end  (window_end)
    );

endmodule

>>> hw/rtl/dmpsl_ctrl.sv
// Sequencing state machine of the dual motor speed loop.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmpsl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  dmpsl_pkg::dmpsl_status_t st,
    output dmpsl_pkg::dmpsl_cmd_t    cmd_o
);
    import dmpsl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ERR  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SAT  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state: window close runs motor A then motor B through err/mul/sat
    always_comb
    begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sel_b_next = 1'b0;
                    state_next = st.win_close ? S_ERR : S_EMIT;
                end
            end
            S_ERR:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (sel_b_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    sel_b_next = 1'b1;
                    state_next = S_ERR;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_o.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Commands
    always_comb
    begin
        cmd_o.load     = accept;
        cmd_o.err_step = (state_reg == S_ERR);
        cmd_o.mul_step = (state_reg == S_MUL);
        cmd_o.sat_step = (state_reg == S_SAT);
        cmd_o.sel_b    = sel_b_reg;
        cmd_o.emit     = (state_reg == S_EMIT) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_b_reg     <= sel_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, cmd_o.emit, out_valid_reg)
    `ASSERT_NEXT(a_b_done_emits, clk, rst_n, cmd_o.sat_step && sel_b_reg, state_reg == S_EMIT)
    `ASSERT_NEXT(a_open_window_skips, clk, rst_n, accept && !st.win_close, state_reg == S_EMIT)

endmodule

>>> hw/rtl/dmpsl_dp.sv
// Datapath of the dual motor speed loop: config, window, duty update, PWM.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmpsl_dp #(
    parameter int POS_WIDTH  = 32,
    parameter int DUTY_WIDTH = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic [dmpsl_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [dmpsl_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic signed [dmpsl_pkg::CMD_W-1:0]         speed_cmd_a,
    input  logic signed [dmpsl_pkg::CMD_W-1:0]         speed_cmd_b,
    input  logic signed [dmpsl_pkg::POS_IN_W-1:0]      enc_pos_a,
    input  logic signed [dmpsl_pkg::POS_IN_W-1:0]      enc_pos_b,
    input  dmpsl_pkg::dmpsl_cmd_t                      cmd,
    output dmpsl_pkg::dmpsl_status_t                   st,
    output logic                                       pwm_a,
    output logic                                       pwm_b,
    output logic                                       dir_a_in1,
    output logic                                       dir_a_in2,
    output logic                                       dir_b_in1,
    output logic                                       dir_b_in2,
    output logic [dmpsl_pkg::DUTY_OUT_W-1:0]           duty_a,
    output logic [dmpsl_pkg::DUTY_OUT_W-1:0]           duty_b,
    output logic                                       window_end
);
    import dmpsl_pkg::*;

    // Derived widths
    localparam int EXTW = (POS_WIDTH > POS_IN_W) ? POS_WIDTH : POS_IN_W;
    localparam int CW   = (POS_WIDTH > DUTY_WIDTH + 3) ? POS_WIDTH : DUTY_WIDTH + 3;
    localparam int MW   = DUTY_WIDTH + 3;
    localparam int ERRW = DUTY_WIDTH + 4;
    localparam int PW   = ERRW + GAIN_W + 1;
    localparam int NDW  = PW + 1;
    localparam int LIMW = (DUTY_WIDTH > PERIOD_W) ? DUTY_WIDTH : PERIOD_W;

    // Measured count clamp at +/-2^(DUTY_WIDTH+1): beyond it any nonzero gain saturates
    localparam logic signed [CW-1:0] MEAS_HI =
        {{(CW - DUTY_WIDTH - 2){1'b0}}, 1'b1, {(DUTY_WIDTH + 1){1'b0}}};
    localparam logic signed [CW-1:0] MEAS_LO = -MEAS_HI;
    localparam logic [LIMW-1:0] DUTY_MAX = LIMW'({DUTY_WIDTH{1'b1}});

    // Configuration registers
    logic [PERIOD_W-1:0] pwm_period_reg;
    logic [WINDOW_W-1:0] window_ticks_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // Loop state
    logic [PERIOD_W-1:0]   period_count_reg, period_count_next;
    logic [WINDOW_W-1:0]   window_count_reg, window_count_next;
    logic [POS_WIDTH-1:0]  last_pos_a_reg, last_pos_b_reg;
    logic [DUTY_WIDTH-1:0] duty_a_reg, duty_b_reg;
    logic                  primed_reg;

    // Per-request working registers
    logic signed [CMD_W-1:0] cmd_a_reg, cmd_b_reg;
    logic [POS_WIDTH-1:0]    delta_a_reg, delta_b_reg;
    logic                    win_close_reg;
    logic signed [ERRW-1:0]  err_reg;
    logic signed [PW-1:0]    prod_reg;

    // Result registers
    logic                  pwm_a_reg, pwm_b_reg;
    logic                  dir_a_in1_reg, dir_a_in2_reg, dir_b_in1_reg, dir_b_in2_reg;
    logic [DUTY_OUT_W-1:0] duty_a_out_reg, duty_b_out_reg;
    logic                  window_end_reg;

    // Combinational terms
    logic signed [EXTW-1:0]  pos_a_wide, pos_b_wide;
    logic [POS_WIDTH-1:0]    pos_a, pos_b;
    logic [WINDOW_W:0]       window_inc;
    logic                    win_close;
    logic signed [CMD_W-1:0] cmd_sel, cmd_neg;
    logic [MAG_W-1:0]        mag_sel;
    logic [TGT_W-1:0]        target_sel;
    logic signed [CW-1:0]    delta_wide;
    logic signed [CW-1:0]    meas_clamped;
    logic signed [MW-1:0]    meas_c;
    logic signed [ERRW-1:0]  err_next;
    logic signed [GAIN_W:0]  gain_s;
    logic [DUTY_WIDTH-1:0]   duty_sel, duty_new;
    logic signed [NDW-1:0]   nd;
    logic [LIMW-1:0]         period_ext, lim;
    logic [PERIOD_W:0]       period_inc;

    // Encoder positions: sign extend or truncate to POS_WIDTH
    assign pos_a_wide = EXTW'(enc_pos_a);
    assign pos_b_wide = EXTW'(enc_pos_b);
    assign pos_a      = pos_a_wide[POS_WIDTH-1:0];
    assign pos_b      = pos_b_wide[POS_WIDTH-1:0];

    // Window bookkeeping: close when count+1 reaches window_ticks
    assign window_inc   = {1'b0, window_count_reg} + 1'b1;
    assign win_close    = primed_reg && (window_inc >= {1'b0, window_ticks_reg});
    assign st.win_close = win_close;

    always_comb
    begin
        window_count_next = window_count_reg;
        if (primed_reg)
        begin
            window_count_next = win_close ? '0 : window_inc[WINDOW_W-1:0];
        end
    end

    // Speed error of the selected motor: clamp(measured) - target
    assign cmd_sel    = cmd.sel_b ? cmd_b_reg : cmd_a_reg;
    assign cmd_neg    = -cmd_sel;
    assign mag_sel    = cmd_sel[CMD_W-1] ? cmd_neg[MAG_W-1:0] : cmd_sel[MAG_W-1:0];
    assign target_sel = target_of(mag_sel);
    assign delta_wide = CW'($signed(cmd.sel_b ? delta_b_reg : delta_a_reg));

    always_comb
    begin
        meas_clamped = delta_wide;
        if (delta_wide > MEAS_HI)
        begin
            meas_clamped = MEAS_HI;
        end
        else if (delta_wide < MEAS_LO)
        begin
            meas_clamped = MEAS_LO;
        end
    end

    assign meas_c   = meas_clamped[MW-1:0];
    assign err_next = ERRW'(meas_c) - ERRW'($signed({1'b0, target_sel}));
    assign gain_s   = $signed({1'b0, gain_reg});

    // Duty update and saturation to 0..min(pwm_period, duty max)
    assign duty_sel   = cmd.sel_b ? duty_b_reg : duty_a_reg;
    assign nd         = NDW'($signed({1'b0, duty_sel})) - NDW'(prod_reg);
    assign period_ext = LIMW'(pwm_period_reg);
    assign lim        = (period_ext < DUTY_MAX) ? period_ext : DUTY_MAX;

    always_comb
    begin
        if (nd < 0)
        begin
            duty_new = '0;
        end
        else if (nd > $signed({{(NDW - LIMW){1'b0}}, lim}))
        begin
            duty_new = lim[DUTY_WIDTH-1:0];
        end
        else
        begin
            duty_new = nd[DUTY_WIDTH-1:0];
        end
    end

    // Period counter advance with wrap at pwm_period
    assign period_inc        = {1'b0, period_count_reg} + 1'b1;
    assign period_count_next = (period_inc >= {1'b0, pwm_period_reg}) ? '0
                                                                      : period_inc[PERIOD_W-1:0];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg   <= RST_PWM_PERIOD;
            window_ticks_reg <= RST_WINDOW_TICKS;
            gain_reg         <= RST_GAIN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PWM_PERIOD:   pwm_period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[WINDOW_W-1:0];
                CFG_GAIN:         gain_reg         <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= '0;
            window_count_reg <= '0;
            last_pos_a_reg   <= '0;
            last_pos_b_reg   <= '0;
            duty_a_reg       <= '0;
            duty_b_reg       <= '0;
            primed_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                window_count_reg <= window_count_next;
                primed_reg       <= 1'b1;
                if (!primed_reg || win_close)
                begin
                    last_pos_a_reg <= pos_a;
                    last_pos_b_reg <= pos_b;
                end
            end
            if (cmd.sat_step)
            begin
                if (cmd.sel_b)
                begin
                    duty_b_reg <= duty_new;
                end
                else
                begin
                    duty_a_reg <= duty_new;
                end
            end
            if (cmd.emit)
            begin
                period_count_reg <= period_count_next;
            end
        end
    end

    // Request capture and arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_a_reg     <= sat_cmd(speed_cmd_a);
            cmd_b_reg     <= sat_cmd(speed_cmd_b);
            delta_a_reg   <= last_pos_a_reg - pos_a;
            delta_b_reg   <= last_pos_b_reg - pos_b;
            win_close_reg <= win_close;
        end
        if (cmd.err_step)
        begin
            err_reg <= err_next;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= PW'(err_reg) * PW'(gain_s);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pwm_a_reg      <= LIMW'(period_count_reg) < LIMW'(duty_a_reg);
            pwm_b_reg      <= LIMW'(period_count_reg) < LIMW'(duty_b_reg);
            dir_a_in1_reg  <= cmd_a_reg[CMD_W-1];
            dir_a_in2_reg  <= !cmd_a_reg[CMD_W-1];
            dir_b_in1_reg  <= !cmd_b_reg[CMD_W-1];
            dir_b_in2_reg  <= cmd_b_reg[CMD_W-1];
            duty_a_out_reg <= DUTY_OUT_W'(duty_a_reg);
            duty_b_out_reg <= DUTY_OUT_W'(duty_b_reg);
            window_end_reg <= win_close_reg;
        end
    end

    assign pwm_a      = pwm_a_reg;
    assign pwm_b      = pwm_b_reg;
    assign dir_a_in1  = dir_a_in1_reg;
    assign dir_a_in2  = dir_a_in2_reg;
    assign dir_b_in1  = dir_b_in1_reg;
    assign dir_b_in2  = dir_b_in2_reg;
    assign duty_a     = duty_a_out_reg;
    assign duty_b     = duty_b_out_reg;
    assign window_end = window_end_reg;

    `ASSERT_NEXT(a_close_clears_window, clk, rst_n, cmd.load && win_close, window_count_reg == '0)
    `ASSERT_NEXT(a_duty_a_bounded, clk, rst_n, cmd.sat_step && !cmd.sel_b, LIMW'(duty_a_reg) <= lim)
    `ASSERT_NEXT(a_duty_b_bounded, clk, rst_n, cmd.sat_step && cmd.sel_b, LIMW'(duty_b_reg) <= lim)

endmodule
